FILE: design/osu_pkg.sv
package osu_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_TICKS_PER_BIT = 2'd0,
    REG_RX_DATA_BITS  = 2'd1,
    REG_TX_DATA_BITS  = 2'd2,
    REG_RX_ENABLE     = 2'd3
  } reg_idx_e;

  localparam logic [7:0] TicksPerBitReset = 8'd3;
  localparam logic [3:0] DataBitsReset    = 4'd8;
  localparam logic [3:0] DataBitsMax      = 4'd8;

  // 0 acts as 1, above 8 acts as 8
  function automatic logic [3:0] clamp_bits(logic [3:0] bits);
    logic [3:0] res;
    res = bits;
    if (bits == 4'd0) begin
      res = 4'd1;
    end else if (bits > DataBitsMax) begin
      res = DataBitsMax;
    end
    return res;
  endfunction

endpackage

FILE: design/osu_if.sv
interface osu_in_if import osu_pkg::*; ();
  logic       valid;
  logic       ready;
  cmd_e       cmd;
  logic       rx_line;
  logic [7:0] send_byte;

  modport source (output valid, cmd, rx_line, send_byte, input ready);
  modport sink   (input valid, cmd, rx_line, send_byte, output ready);
endinterface

interface osu_out_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       send_taken;
  logic       read_valid;
  logic [7:0] read_data;
  logic       rx_pending;

  modport source (output valid, tx_line, tx_busy, send_taken, read_valid, read_data,
                  rx_pending, input ready);
  modport sink   (input valid, tx_line, tx_busy, send_taken, read_valid, read_data,
                  rx_pending, output ready);
endinterface

FILE: design/oversampled_soft_uart_with_rx_fifo.sv
// Oversampled soft UART with a receive FIFO. Every input word (a tick carrying the sampled
// receive pin, a send, a read or a FIFO flush) yields exactly one result word. When a word
// is taken, the transmitter and receiver counters and the FIFO indices update at the
// accepting edge and the result lands in an output register, so the block accepts
// one word per clock as long as the result side keeps taking words; while a result waits
// unread the input is held off. The FIFO store is a FIFO_DEPTH x 8 memory whose read port
// feeds the read_data field of the output register directly. Configuration registers sit
// behind an APB-style port (ticks_per_bit at 0x0, rx_data_bits at 0x4, tx_data_bits at
// 0x8, rx_enable at 0xC) and should be written only while the block is idle.
module oversampled_soft_uart_with_rx_fifo import osu_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  osu_in_if.sink      in_i,
  osu_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(FIFO_DEPTH - 1);

  // config
  logic [7:0] tpb_q;
  logic [3:0] rx_bits_q, tx_bits_q;
  logic       rx_en_q;
  reg_idx_e   reg_sel;

  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q     <= TicksPerBitReset;
      rx_bits_q <= DataBitsReset;
      tx_bits_q <= DataBitsReset;
      rx_en_q   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_TICKS_PER_BIT: tpb_q     <= pwdata[7:0];
        REG_RX_DATA_BITS:  rx_bits_q <= pwdata[3:0];
        REG_TX_DATA_BITS:  tx_bits_q <= pwdata[3:0];
        REG_RX_ENABLE:     rx_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TICKS_PER_BIT: prdata = {24'd0, tpb_q};
      REG_RX_DATA_BITS:  prdata = {28'd0, rx_bits_q};
      REG_TX_DATA_BITS:  prdata = {28'd0, tx_bits_q};
      REG_RX_ENABLE:     prdata = {31'd0, rx_en_q};
      default:           prdata = '0;
    endcase
  end

  // state
  logic            tx_active_q, tx_active_d;
  logic            tx_start_q, tx_start_d;
  logic            tx_stop_q, tx_stop_d;
  logic [7:0]      tx_cnt_q, tx_cnt_d;
  logic [3:0]      tx_rem_q, tx_rem_d;
  logic [7:0]      tx_hold_q, tx_hold_d;
  logic            tx_level_q, tx_level_d;
  logic            rx_frame_q, rx_frame_d;
  logic            rx_stopw_q, rx_stopw_d;
  logic [8:0]      rx_cnt_q, rx_cnt_d;
  logic [3:0]      rx_rem_q, rx_rem_d;
  logic [7:0]      rx_asm_q, rx_asm_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  logic       in_acc, taken, rd_hit, mem_we;
  logic [7:0] period;
  logic [3:0] tx_bits, rx_bits, tx_pos_w, rx_pos_w;
  logic       out_valid_q;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign period     = (tpb_q == 8'd0) ? 8'd1 : tpb_q;
  assign tx_bits    = clamp_bits(tx_bits_q);
  assign rx_bits    = clamp_bits(rx_bits_q);
  assign tx_pos_w   = tx_bits - tx_rem_q;
  assign rx_pos_w   = rx_bits - rx_rem_q;

  always_comb begin
    tx_active_d = tx_active_q;
    tx_start_d  = tx_start_q;
    tx_stop_d   = tx_stop_q;
    tx_cnt_d    = tx_cnt_q;
    tx_rem_d    = tx_rem_q;
    tx_hold_d   = tx_hold_q;
    tx_level_d  = tx_level_q;
    rx_frame_d  = rx_frame_q;
    rx_stopw_d  = rx_stopw_q;
    rx_cnt_d    = rx_cnt_q;
    rx_rem_d    = rx_rem_q;
    rx_asm_d    = rx_asm_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    taken       = 1'b0;
    rd_hit      = 1'b0;
    mem_we      = 1'b0;

    if (in_acc) begin
      case (in_i.cmd)
        CMD_TICK: begin
          // transmitter
          if (tx_active_q) begin
            if (tx_cnt_q <= 8'd1) begin
              tx_cnt_d = period;
              if (!tx_start_q) begin
                tx_level_d = 1'b0;
                tx_start_d = 1'b1;
              end else if (!tx_stop_q) begin
                tx_level_d = tx_hold_q[tx_pos_w[2:0]];
                if (tx_rem_q <= 4'd1) begin
                  tx_rem_d  = 4'd0;
                  tx_stop_d = 1'b1;
                end else begin
                  tx_rem_d = tx_rem_q - 4'd1;
                end
              end else begin
                tx_level_d  = 1'b1;
                tx_stop_d   = 1'b0;
                tx_start_d  = 1'b0;
                tx_active_d = 1'b0;
              end
            end else begin
              tx_cnt_d = tx_cnt_q - 8'd1;
            end
          end
          // receiver
          if (rx_en_q) begin
            if (rx_stopw_q) begin
              if (rx_cnt_q <= 9'd1) begin
                rx_stopw_d = 1'b0;
                rx_frame_d = 1'b0;
                mem_we     = 1'b1;
                wr_idx_d   = (wr_idx_q == IdxLast) ? '0 : wr_idx_q + 1'b1;
              end else begin
                rx_cnt_d = rx_cnt_q - 9'd1;
              end
            end else if (!rx_frame_q) begin
              if (!in_i.rx_line) begin
                rx_frame_d = 1'b1;
                rx_asm_d   = '0;
                rx_cnt_d   = {1'b0, period} + 9'd1;
                rx_rem_d   = rx_bits;
              end
            end else if (rx_cnt_q <= 9'd1) begin
              rx_cnt_d = {1'b0, period};
              rx_asm_d = rx_asm_q | (8'(in_i.rx_line) << rx_pos_w[2:0]);
              if (rx_rem_q <= 4'd1) begin
                rx_rem_d   = 4'd0;
                rx_stopw_d = 1'b1;
              end else begin
                rx_rem_d = rx_rem_q - 4'd1;
              end
            end else begin
              rx_cnt_d = rx_cnt_q - 9'd1;
            end
          end
        end
        CMD_SEND: begin
          if (!tx_active_q) begin
            tx_cnt_d    = period;
            tx_rem_d    = tx_bits;
            tx_hold_d   = in_i.send_byte;
            tx_active_d = 1'b1;
            tx_start_d  = 1'b0;
            tx_stop_d   = 1'b0;
            taken       = 1'b1;
          end
        end
        CMD_READ: begin
          if (rd_idx_q != wr_idx_q) begin
            rd_hit   = 1'b1;
            rd_idx_d = (rd_idx_q == IdxLast) ? '0 : rd_idx_q + 1'b1;
          end
        end
        CMD_FLUSH: begin
          wr_idx_d = '0;
          rd_idx_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_active_q <= 1'b0;
      tx_start_q  <= 1'b0;
      tx_stop_q   <= 1'b0;
      tx_cnt_q    <= '0;
      tx_rem_q    <= '0;
      tx_hold_q   <= '0;
      tx_level_q  <= 1'b1;
      rx_frame_q  <= 1'b0;
      rx_stopw_q  <= 1'b0;
      rx_cnt_q    <= '0;
      rx_rem_q    <= '0;
      rx_asm_q    <= '0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
    end else begin
      tx_active_q <= tx_active_d;
      tx_start_q  <= tx_start_d;
      tx_stop_q   <= tx_stop_d;
      tx_cnt_q    <= tx_cnt_d;
      tx_rem_q    <= tx_rem_d;
      tx_hold_q   <= tx_hold_d;
      tx_level_q  <= tx_level_d;
      rx_frame_q  <= rx_frame_d;
      rx_stopw_q  <= rx_stopw_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_rem_q    <= rx_rem_d;
      rx_asm_q    <= rx_asm_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  // receive store, read data goes straight into the result word
  logic [7:0] mem_q [FIFO_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= rx_asm_q;
    end
    if (in_acc) begin
      rdata_q <= rd_hit ? mem_q[rd_idx_q] : 8'd0;
    end
  end

  // result word
  logic tx_line_q, tx_busy_q, taken_q, rvalid_q, pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_line_q <= tx_level_d;
      tx_busy_q <= tx_active_d;
      taken_q   <= taken;
      rvalid_q  <= rd_hit;
      pending_q <= (rd_idx_d != wr_idx_d);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.tx_line    = tx_line_q;
  assign out_o.tx_busy    = tx_busy_q;
  assign out_o.send_taken = taken_q;
  assign out_o.read_valid = rvalid_q;
  assign out_o.read_data  = rdata_q;
  assign out_o.rx_pending = pending_q;

endmodule

FILE: design/osu_checker.sv
module osu_checker import osu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input cmd_e       in_cmd_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       tx_line_i,
  input logic       tx_busy_i,
  input logic       send_taken_i,
  input logic       read_valid_i,
  input logic [7:0] read_data_i,
  input logic       rx_pending_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // every accepted word gives a result word on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("no result word after accepted input word");

  a_taken_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i != CMD_SEND |=> !send_taken_i)
    else $error("send_taken without a send");

  a_read_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i != CMD_READ |=> !read_valid_i && read_data_i == 8'd0)
    else $error("read data without a read");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i == CMD_FLUSH |=> !rx_pending_i)
    else $error("fifo not empty after flush");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_line_i) && $stable(tx_busy_i)
      && $stable(send_taken_i) && $stable(read_valid_i) && $stable(read_data_i)
      && $stable(rx_pending_i))
    else $error("result word changed while stalled");

endmodule

bind oversampled_soft_uart_with_rx_fifo osu_checker u_osu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .tx_line_i    (out_o.tx_line),
  .tx_busy_i    (out_o.tx_busy),
  .send_taken_i (out_o.send_taken),
  .read_valid_i (out_o.read_valid),
  .read_data_i  (out_o.read_data),
  .rx_pending_i (out_o.rx_pending)
);
